// ===== src/erps_pkg.sv =====
package erps_pkg;

	localparam int WIN_DEPTH     = 9;
	localparam int NUM_PATS      = 14;
	localparam int BASENAME_KEPT = 6;
	localparam int LEN_W         = $clog2(BASENAME_KEPT + 2);

	localparam logic [15:0] ENTROPY_LIMIT_RESET = 16'd1920;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// subsystem codes
	localparam logic [2:0] SUB_PROCESS = 3'd0;
	localparam logic [2:0] SUB_TOOL    = 3'd1;
	localparam logic [2:0] SUB_ENTROPY = 3'd2;
	localparam logic [2:0] SUB_FS      = 3'd3;

	// action codes
	localparam logic [2:0] ACT_EXEC  = 3'd0;
	localparam logic [2:0] ACT_TOOL  = 3'd1;
	localparam logic [2:0] ACT_WRITE = 3'd2;
	localparam logic [2:0] ACT_OPEN  = 3'd3;

	// payload classes
	localparam logic [1:0] CLS_CRYPTO = 2'd1;
	localparam logic [1:0] CLS_BASE64 = 2'd2;
	localparam logic [1:0] CLS_HEX    = 2'd3;

	// pattern hit groups
	localparam logic [NUM_PATS-1:0] M_NET    = 14'h0003;
	localparam logic [NUM_PATS-1:0] M_PIPE   = 14'h003C;
	localparam logic [NUM_PATS-1:0] M_DANGER = 14'h07C0;
	localparam logic [NUM_PATS-1:0] M_PROT   = 14'h3800;

	// protected path patterns, oldest byte in the top bits
	localparam logic [55:0] PAT_PROT_DIR  = 56'h2E636C61756465;
	localparam logic [71:0] PAT_PROT_DOC1 = 72'h434C415544452E6D64;
	localparam logic [71:0] PAT_PROT_DOC2 = 72'h4147454E54532E6D64;

	// index 0 is the newest byte
	typedef logic [WIN_DEPTH-1:0][7:0] window_t;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_TOKEN,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic anomaly;
		logic blocked;
		logic lolbas;
		logic crypto_flag;
		logic base64_flag;
		logic hex_flag;
		logic verdict_ok;
	} result_t;

endpackage

// ===== src/erps_cell.sv =====
module erps_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clr,
	input  logic       en,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clr) begin
			byte_q <= '0;
		end else if (en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

// ===== src/erps_window.sv =====
module erps_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          en,
	input  logic [7:0]                    b,
	output logic [erps_pkg::NUM_PATS-1:0] hits_next
);

	erps_pkg::window_t win;
	erps_pkg::window_t win_n;
	logic [erps_pkg::NUM_PATS-1:0] match;
	logic [erps_pkg::NUM_PATS-1:0] hits_q;

	// cell 0 takes the new byte, every other cell takes its neighbor
	for (genvar i = 0; i < erps_pkg::WIN_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			erps_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.clr    (clr),
				.en     (en),
				.d      (b),
				.q      (win[i])
			);
		end else begin : g_body
			erps_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.clr    (clr),
				.en     (en),
				.d      (win[i-1]),
				.q      (win[i])
			);
		end
	end

	always_comb begin
		win_n[0] = b;
		for (int i = 1; i < erps_pkg::WIN_DEPTH; i++) begin
			win_n[i] = win[i-1];
		end
	end

	// match at the tail of the window as it stands after this byte
	always_comb begin
		match     = '0;
		match[0]  = (win_n[3:0] == "curl");
		match[1]  = (win_n[3:0] == "wget");
		match[2]  = (win_n[3:0] == "| sh");
		match[3]  = (win_n[5:0] == "| bash");
		match[4]  = (win_n[2:0] == "|sh");
		match[5]  = (win_n[4:0] == "|bash");
		match[6]  = (win_n[5:0] == "rm -rf");
		match[7]  = (win_n[5:0] == "rm -r ");
		match[8]  = (win_n[8:0] == "chmod 777");
		match[9]  = (win_n[3:0] == "mkfs");
		match[10] = (win_n[5:0] == "dd if=");
		match[11] = (win_n[6:0] == erps_pkg::PAT_PROT_DIR);
		match[12] = (win_n[8:0] == erps_pkg::PAT_PROT_DOC1);
		match[13] = (win_n[8:0] == erps_pkg::PAT_PROT_DOC2);
	end

	assign hits_next = en ? (hits_q | match) : hits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
		end else if (clr) begin
			hits_q <= '0;
		end else begin
			hits_q <= hits_next;
		end
	end

endmodule

// ===== src/erps_token.sv =====
module erps_token (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       clr,
	input  logic       en,
	input  logic [7:0] b,
	output logic       listed
);

	erps_pkg::phase_t phase_q, phase_n;
	logic [erps_pkg::BASENAME_KEPT-1:0][7:0] chars_q, chars_n;
	logic [erps_pkg::LEN_W-1:0] len_q, len_n;
	logic is_blank;
	logic is_break;

	function automatic logic base_is(
		input logic [erps_pkg::BASENAME_KEPT-1:0][7:0] c,
		input logic [erps_pkg::LEN_W-1:0]              l,
		input logic [47:0]                             w,
		input int                                      n,
		input logic                                    prefix
	);
		logic ok;
		ok = prefix ? (int'(l) >= n) : (int'(l) == n);
		for (int i = 0; i < 6; i++) begin
			if (i < n && c[i] != w[8*(n-1-i) +: 8]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	assign is_blank = (b == erps_pkg::CH_SPACE) || (b == erps_pkg::CH_TAB);
	assign is_break = is_blank || (b == erps_pkg::CH_CR) || (b == erps_pkg::CH_LF);

	always_comb begin
		phase_n = phase_q;
		chars_n = chars_q;
		len_n   = len_q;
		if (en) begin
			unique case (phase_q) inside
				erps_pkg::PH_LEAD, erps_pkg::PH_TOKEN: begin
					if (phase_q == erps_pkg::PH_LEAD && is_blank) begin
						phase_n = erps_pkg::PH_LEAD;
					end else if (is_break) begin
						phase_n = erps_pkg::PH_DONE;
					end else if (b == erps_pkg::CH_SLASH) begin
						phase_n = erps_pkg::PH_TOKEN;
						len_n   = '0;
					end else begin
						phase_n = erps_pkg::PH_TOKEN;
						for (int i = 0; i < erps_pkg::BASENAME_KEPT; i++) begin
							if (int'(len_q) == i) begin
								chars_n[i] = b;
							end
						end
						if (int'(len_q) <= erps_pkg::BASENAME_KEPT) begin
							len_n = len_q + {{(erps_pkg::LEN_W-1){1'b0}}, 1'b1};
						end
					end
				end
				erps_pkg::PH_DONE: begin
					phase_n = erps_pkg::PH_DONE;
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= erps_pkg::PH_LEAD;
			chars_q <= '0;
			len_q   <= '0;
		end else if (clr) begin
			phase_q <= erps_pkg::PH_LEAD;
			chars_q <= '0;
			len_q   <= '0;
		end else begin
			phase_q <= phase_n;
			chars_q <= chars_n;
			len_q   <= len_n;
		end
	end

	// judge the basename as it stands after this byte
	always_comb begin
		listed = (len_n != '0) && (
			base_is(chars_n, len_n, 48'("curl"), 4, 1'b0) ||
			base_is(chars_n, len_n, 48'("wget"), 4, 1'b0) ||
			base_is(chars_n, len_n, 48'("nc"), 2, 1'b0) ||
			base_is(chars_n, len_n, 48'("ncat"), 4, 1'b0) ||
			base_is(chars_n, len_n, 48'("netcat"), 6, 1'b0) ||
			base_is(chars_n, len_n, 48'("socat"), 5, 1'b0) ||
			base_is(chars_n, len_n, 48'("base64"), 6, 1'b0) ||
			base_is(chars_n, len_n, 48'("python"), 6, 1'b1) ||
			base_is(chars_n, len_n, 48'("perl"), 4, 1'b0) ||
			base_is(chars_n, len_n, 48'("ruby"), 4, 1'b0) ||
			base_is(chars_n, len_n, 48'("php"), 3, 1'b1) ||
			base_is(chars_n, len_n, 48'("lua"), 3, 1'b1) ||
			base_is(chars_n, len_n, 48'("sh"), 2, 1'b0) ||
			base_is(chars_n, len_n, 48'("bash"), 4, 1'b0) ||
			base_is(chars_n, len_n, 48'("zsh"), 3, 1'b0) ||
			base_is(chars_n, len_n, 48'("dash"), 4, 1'b0) ||
			base_is(chars_n, len_n, 48'("ash"), 3, 1'b0));
	end

endmodule

// ===== src/event_rule_pattern_screen.sv =====
// Throughput: one payload byte per cycle while in_stall is low.
// The verdict of a payload is registered when its last byte is accepted.
// A result waiting on out_stall moves into a one-entry skid register, and
// in_stall rises only while that skid register is full.
// Reset (arst_n low, asynchronous): clears the byte window, pattern hits, token
// parser, NUL flag and both output valid flags; entropy_limit returns to 1920.
module event_rule_pattern_screen (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  subsystem,
	input  logic [2:0]  action,
	input  logic        in_crypto,
	input  logic        in_base64,
	input  logic        in_hex,
	input  logic [15:0] entropy_q8,
	input  logic [1:0]  payload_class,
	input  logic [7:0]  payload_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        anomaly,
	output logic        blocked,
	output logic        lolbas,
	output logic        crypto_flag,
	output logic        base64_flag,
	output logic        hex_flag,
	output logic        verdict_ok
);

	logic [15:0] limit_q;
	logic        nul_q;
	logic        acc;
	logic        shift_en;
	logic        clr;
	logic        listed;
	logic        bad;
	logic [erps_pkg::NUM_PATS-1:0] hits;
	erps_pkg::result_t res;
	erps_pkg::result_t out_q;
	erps_pkg::result_t skid_q;
	logic        out_v_q;
	logic        skid_v_q;
	logic        out_fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= erps_pkg::ENTROPY_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	assign in_stall = skid_v_q;
	assign acc      = in_valid && !in_stall;
	assign shift_en = acc && !nul_q && (payload_byte != erps_pkg::CH_NUL);
	assign clr      = acc && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nul_q <= 1'b0;
		end else if (clr) begin
			nul_q <= 1'b0;
		end else if (acc && payload_byte == erps_pkg::CH_NUL) begin
			nul_q <= 1'b1;
		end
	end

	erps_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (clr),
		.en        (shift_en),
		.b         (payload_byte),
		.hits_next (hits)
	);

	erps_token u_token (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.en     (shift_en),
		.b      (payload_byte),
		.listed (listed)
	);

	assign bad = (|(hits & (erps_pkg::M_DANGER | erps_pkg::M_PROT))) ||
		((|(hits & erps_pkg::M_NET)) && (|(hits & erps_pkg::M_PIPE))) || in_crypto;

	always_comb begin
		res             = '0;
		res.crypto_flag = in_crypto;
		res.base64_flag = in_base64;
		res.hex_flag    = in_hex;
		unique case (subsystem)
			erps_pkg::SUB_PROCESS: begin
				if (action == erps_pkg::ACT_EXEC) begin
					if (listed) begin
						res.lolbas  = 1'b1;
						res.anomaly = 1'b1;
					end else begin
						res.verdict_ok = 1'b1;
					end
				end
			end
			erps_pkg::SUB_TOOL: begin
				if (action == erps_pkg::ACT_TOOL) begin
					if (bad) begin
						res.blocked = 1'b1;
						res.anomaly = 1'b1;
					end else begin
						res.verdict_ok = 1'b1;
					end
				end
			end
			erps_pkg::SUB_ENTROPY: begin
				if (payload_class == erps_pkg::CLS_CRYPTO || entropy_q8 >= limit_q ||
						in_crypto) begin
					res.anomaly     = 1'b1;
					res.blocked     = 1'b1;
					res.crypto_flag = 1'b1;
				end else if (payload_class == erps_pkg::CLS_BASE64 || in_base64) begin
					res.anomaly     = 1'b1;
					res.base64_flag = 1'b1;
				end else if (payload_class == erps_pkg::CLS_HEX || in_hex) begin
					res.anomaly  = 1'b1;
					res.hex_flag = 1'b1;
				end else begin
					res.verdict_ok = 1'b1;
				end
			end
			erps_pkg::SUB_FS: begin
				if (|(hits & erps_pkg::M_PROT)) begin
					if (action == erps_pkg::ACT_WRITE || action == erps_pkg::ACT_OPEN) begin
						res.blocked = 1'b1;
						res.anomaly = 1'b1;
					end
				end else begin
					res.verdict_ok = 1'b1;
				end
			end
			default: begin
				res.verdict_ok = 1'b1;
			end
		endcase
	end

	assign out_fire = out_v_q && !out_stall;

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_fire) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= clr;
			end
		end else if (clr) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_fire) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (clr) begin
				out_q <= res;
			end
		end else if (clr) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_v_q;
	assign anomaly     = out_q.anomaly;
	assign blocked     = out_q.blocked;
	assign lolbas      = out_q.lolbas;
	assign crypto_flag = out_q.crypto_flag;
	assign base64_flag = out_q.base64_flag;
	assign hex_flag    = out_q.hex_flag;
	assign verdict_ok  = out_q.verdict_ok;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_byte) |=> out_valid)
		else $error("no result after last byte");

	a_ok_excludes_anomaly: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(verdict_ok && anomaly))
		else $error("verdict_ok together with anomaly");

	a_block_is_anomaly: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (blocked || lolbas)) |-> anomaly)
		else $error("blocked or lolbas without anomaly");

endmodule
